@@ src/tcl_pkg.sv @@
// ----------------------------------------------------------------------------
// tcl_pkg: shared definitions for the thermocouple cold-junction linearizer
// Widths, scale constants, the type K millivolt table and the divider
// request/response types.
// ----------------------------------------------------------------------------
package tcl_pkg;

  // Field widths
  localparam int CODE_W = 10;
  localparam int OUT_W  = 16;
  localparam int CFG_IDX_W = 1;

  // Sensor select codes
  localparam logic OP_THERMISTOR   = 1'b0;
  localparam logic OP_THERMOCOUPLE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TC_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TH_OFFSET = 1'b1;

  // Table
  localparam int ROM_SIZE          = 151;
  localparam int TABLE_ENTRIES_DEF = 151;
  localparam int UV_W              = 13;

  // Internal widths
  localparam int V_W        = 31;  // voltage in 1/190584 uV units
  localparam int CT_W       = 30;  // couple code times gain
  localparam int THN_W      = 26;  // thermistor dividend
  localparam int RCP_W      = 27;  // reciprocal of the thermistor divisor
  localparam int THP_W      = THN_W + RCP_W;
  localparam int RCP_SH     = 38;  // reciprocal scale, 2**RCP_SH
  localparam int THQ_W      = 15;  // thermistor quotient
  localparam int WIDE_W     = 18;  // signed Q10.8 before saturation
  localparam int CJ_W       = 9;   // whole degrees of a positive wide value
  localparam int FRAC_QW    = 9;
  localparam int DIV_W      = 32;
  localparam int DIV_QW     = FRAC_QW;
  localparam int DIV_CNT_W  = 4;
  localparam int FRAC_NUM_W = V_W + FRAC_QW + 1;

  // Scale constants
  localparam logic [V_W-1:0]   V_SCALE    = 31'd190584;
  localparam logic [CT_W-1:0]  CODE_GAIN  = 30'd859375;
  // Thermistor: floor((55000*jc + 1565) / 2117) - 5951 gives the rounded
  // Q8.8 value including the +10 degree term; the bias keeps the dividend
  // positive. The divide is a multiply by ceil(2**38 / 2117) and a shift,
  // exact for every dividend below 2**26.
  localparam logic [THN_W-1:0] THERM_GAIN  = 26'd55000;
  localparam logic [THN_W-1:0] THERM_BIAS  = 26'd1565;
  localparam logic [RCP_W-1:0] THERM_RECIP = 27'd129843131;
  localparam logic signed [WIDE_W-1:0] THERM_SHIFT = 18'sd5951;

  localparam logic signed [WIDE_W-1:0] SAT_HI = 18'sd32767;
  localparam logic signed [WIDE_W-1:0] SAT_LO = -18'sd32768;

  // Type K table, microvolts at 0..150 degrees
  localparam logic [UV_W-1:0] ROM_UV [ROM_SIZE] = '{
    13'd0,    13'd39,   13'd79,   13'd119,  13'd158,  13'd198,  13'd238,  13'd277,
    13'd317,  13'd357,  13'd397,  13'd437,  13'd477,  13'd517,  13'd557,  13'd597,
    13'd637,  13'd677,  13'd718,  13'd758,  13'd798,  13'd838,  13'd879,  13'd919,
    13'd960,  13'd1000, 13'd1041, 13'd1081, 13'd1122, 13'd1163, 13'd1203, 13'd1244,
    13'd1285, 13'd1326, 13'd1366, 13'd1407, 13'd1448, 13'd1489, 13'd1530, 13'd1571,
    13'd1612, 13'd1653, 13'd1694, 13'd1735, 13'd1776, 13'd1817, 13'd1858, 13'd1899,
    13'd1941, 13'd1982, 13'd2023, 13'd2064, 13'd2106, 13'd2147, 13'd2188, 13'd2230,
    13'd2271, 13'd2312, 13'd2354, 13'd2395, 13'd2436, 13'd2478, 13'd2519, 13'd2561,
    13'd2602, 13'd2644, 13'd2685, 13'd2727, 13'd2768, 13'd2810, 13'd2851, 13'd2893,
    13'd2934, 13'd2976, 13'd3017, 13'd3059, 13'd3100, 13'd3142, 13'd3184, 13'd3225,
    13'd3267, 13'd3308, 13'd3350, 13'd3391, 13'd3433, 13'd3474, 13'd3516, 13'd3557,
    13'd3599, 13'd3640, 13'd3680, 13'd3723, 13'd3765, 13'd3806, 13'd3848, 13'd3889,
    13'd3931, 13'd3972, 13'd4013, 13'd4055, 13'd4096, 13'd4138, 13'd4179, 13'd4220,
    13'd4262, 13'd4303, 13'd4344, 13'd4385, 13'd4427, 13'd4468, 13'd4509, 13'd4550,
    13'd4591, 13'd4633, 13'd4674, 13'd4715, 13'd4756, 13'd4797, 13'd4838, 13'd4879,
    13'd4920, 13'd4961, 13'd5002, 13'd5043, 13'd5084, 13'd5124, 13'd5165, 13'd5206,
    13'd5247, 13'd5288, 13'd5328, 13'd5369, 13'd5410, 13'd5450, 13'd5491, 13'd5532,
    13'd5572, 13'd5613, 13'd5653, 13'd5694, 13'd5735, 13'd5775, 13'd5815, 13'd5856,
    13'd5896, 13'd5937, 13'd5977, 13'd6017, 13'd6058, 13'd6098, 13'd6138
  };

  // Serial divider handshake
  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     rem_init;  // dividend high part, below divisor
    logic [DIV_QW-1:0]    low;       // remaining dividend bits, MSB first
    logic [DIV_W-1:0]     divisor;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              busy;
    logic [DIV_QW-1:0] quot;
  } div_rsp_t;

endpackage

@@ src/tcl_if.sv @@
// ----------------------------------------------------------------------------
// tcl channel interfaces
// Valid/ready channels for sensor codes, temperature results and
// register writes.
// ----------------------------------------------------------------------------
interface tcl_in_if import tcl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [CODE_W-1:0] couple_code;
  logic [CODE_W-1:0] junction_code;

  modport source (output valid, output op, output couple_code, output junction_code,
                  input ready);
  modport sink   (input valid, input op, input couple_code, input junction_code,
                  output ready);
endinterface

interface tcl_out_if import tcl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] temperature;
  logic                    in_range;

  modport source (output valid, output temperature, output in_range, input ready);
  modport sink   (input valid, input temperature, input in_range, output ready);
endinterface

interface tcl_cfg_if import tcl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [OUT_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/tcl_div.sv @@
// ----------------------------------------------------------------------------
// tcl_div: restoring serial divider
// One quotient bit per cycle; the caller pre-aligns the dividend so the
// quotient fits in the requested number of steps.
// ----------------------------------------------------------------------------
module tcl_div import tcl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     rem_q, div_q, rem_next;
  logic [DIV_QW-1:0]    low_q, quot_q;
  logic [DIV_W:0]       trial;
  logic                 fits;

  assign trial    = {rem_q, low_q[DIV_QW-1]};
  assign fits     = trial >= {1'b0, div_q};
  assign rem_next = fits ? DIV_W'(trial - {1'b0, div_q}) : trial[DIV_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.rem_init;
      div_q  <= req_i.divisor;
      low_q  <= req_i.low;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_next;
      low_q  <= {low_q[DIV_QW-2:0], 1'b0};
      quot_q <= {quot_q[DIV_QW-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.busy = busy_q;
  assign rsp_o.quot = quot_q;

endmodule

@@ src/thermocouple_cjc_linearizer_top.sv @@
// ----------------------------------------------------------------------------
// thermocouple_cjc_linearizer_top: type K reader with cold-junction compensation
// Converts thermistor and thermocouple ADC means to signed Q8.8 degrees.
// ----------------------------------------------------------------------------
// One item is in work at a time. A thermistor item (op 0) forms the dividend,
// multiplies it by the reciprocal of the constant divisor, then adds the
// offset. A thermocouple item (op 1) takes the same steps for the cold
// junction, reads the cold-junction voltage and table entry 0, then walks
// the millivolt table one entry per cycle from entry 1 up to the matching
// segment (up to NumEntries-1 reads of the synchronous table), then runs a
// 9-step serial divide for the interpolation fraction. Input ready returns
// together with the loaded result. A result waits in the output register
// without blocking the next input transfer; a second finished result holds
// the block until the first one leaves. Register writes are always accepted
// and must only be issued while the block is idle.
// The cold junction is the thermistor value truncated to whole degrees and
// clamped to the table; a voltage outside the table returns
// thermocouple_offset with in_range cleared. Results saturate to the 16-bit
// signed range.
// ----------------------------------------------------------------------------
module thermocouple_cjc_linearizer_top import tcl_pkg::*; #(
  parameter int TableEntries = TABLE_ENTRIES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcl_in_if.sink    in_i,
  tcl_out_if.source out_o,
  tcl_cfg_if.sink   cfg_i
);

  localparam int NumEntries = (TableEntries < ROM_SIZE) ? TableEntries : ROM_SIZE;
  localparam int AddrW      = $clog2(NumEntries);
  localparam int LastIdx    = NumEntries - 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_JT,
    S_JT_MUL,
    S_JT_WAIT,
    S_CJ,
    S_CJ_RD,
    S_LO,
    S_SEARCH,
    S_FRAC,
    S_FRAC_WAIT,
    S_OUT
  } state_e;

  // Control and registered outputs
  state_e                  state_q, state_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [OUT_W-1:0] temp_q, temp_d;
  logic                    in_range_q, in_range_d;
  logic signed [OUT_W-1:0] tc_off_q, tc_off_d, th_off_q, th_off_d;

  // Datapath registers
  logic              op_q, op_d;
  logic [CODE_W-1:0] cc_q, cc_d, jc_q, jc_d;
  logic signed [WIDE_W-1:0] jt_q, jt_d, res_q, res_d;
  logic              ok_q, ok_d;
  logic [THN_W-1:0]  therm_num_q, therm_num_d;
  logic [THP_W-1:0]  therm_prod_q, therm_prod_d;
  logic [CT_W-1:0]   cc_term_q, cc_term_d;
  logic [V_W-1:0]    v_q, v_d, lo_s_q, lo_s_d, den_q, den_d, diff_q, diff_d;
  logic [AddrW-1:0]  idx_q, idx_d, seg_q, seg_d;

  // Table memory
  logic [AddrW-1:0]  rom_addr;
  logic [UV_W-1:0]   rom_q;

  // Derived values
  logic [V_W-1:0]           rom_scaled;
  logic                     hit;
  logic [THN_W-1:0]         therm_num;
  logic [FRAC_NUM_W-1:0]    frac_num;
  logic signed [WIDE_W-1:0] jt_new, tc_off_w, th_off_w;
  logic [CJ_W-1:0]          cj_full;
  logic [AddrW-1:0]         cj_addr;

  div_req_t div_req;
  div_rsp_t div_rsp;

  tcl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Synchronous table read, registered
  always_ff @(posedge clk_i) begin
    rom_q <= ROM_UV[rom_addr];
  end

  assign rom_scaled = {{(V_W-UV_W){1'b0}}, rom_q} * V_SCALE;
  // Segment test: strictly rising step, both bounds inclusive
  assign hit = (rom_scaled > lo_s_q) && (v_q >= lo_s_q) && (v_q <= rom_scaled);

  assign therm_num = {{(THN_W-CODE_W){1'b0}}, jc_q} * THERM_GAIN + THERM_BIAS;
  // 512*(v-lo) + den, divided later by 2*den for a half-up rounded fraction
  assign frac_num  = {1'b0, diff_q, {FRAC_QW{1'b0}}} + FRAC_NUM_W'(den_q);

  assign tc_off_w = {{(WIDE_W-OUT_W){tc_off_q[OUT_W-1]}}, tc_off_q};
  assign th_off_w = {{(WIDE_W-OUT_W){th_off_q[OUT_W-1]}}, th_off_q};
  // Quotient of the thermistor divide sits above the reciprocal scale
  assign jt_new   = $signed({{(WIDE_W-THQ_W){1'b0}}, therm_prod_q[THP_W-1:RCP_SH]})
                    - THERM_SHIFT + th_off_w;

  // Cold junction: negative goes to zero, clamp to the last table entry
  assign cj_full = jt_q[WIDE_W-1] ? '0 : jt_q[WIDE_W-2:8];
  assign cj_addr = (cj_full > CJ_W'(LastIdx)) ? AddrW'(LastIdx) : cj_full[AddrW-1:0];

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q;
    temp_d       = temp_q;
    in_range_d   = in_range_q;
    tc_off_d     = tc_off_q;
    th_off_d     = th_off_q;
    op_d         = op_q;
    cc_d         = cc_q;
    jc_d         = jc_q;
    jt_d         = jt_q;
    res_d        = res_q;
    ok_d         = ok_q;
    therm_num_d  = therm_num_q;
    therm_prod_d = therm_prod_q;
    cc_term_d    = cc_term_q;
    v_d          = v_q;
    lo_s_d       = lo_s_q;
    den_d        = den_q;
    diff_d       = diff_q;
    idx_d        = idx_q;
    seg_d        = seg_q;
    rom_addr     = '0;
    div_req      = '0;

    // Drop the result once the sink takes it
    if (out_o.valid && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CFG_TC_OFFSET: tc_off_d = $signed(cfg_i.data);
        CFG_TH_OFFSET: th_off_d = $signed(cfg_i.data);
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d    = in_i.op;
          cc_d    = in_i.couple_code;
          jc_d    = in_i.junction_code;
          state_d = S_JT;
        end
      end
      S_JT: begin
        therm_num_d = therm_num;
        state_d     = S_JT_MUL;
      end
      S_JT_MUL: begin
        // Divide by the constant as a multiply by its scaled reciprocal
        therm_prod_d = THP_W'(therm_num_q) * THP_W'(THERM_RECIP);
        state_d      = S_JT_WAIT;
      end
      S_JT_WAIT: begin
        jt_d = jt_new;
        if (op_q == OP_THERMISTOR) begin
          res_d   = jt_new;
          ok_d    = 1'b1;
          state_d = S_OUT;
        end else begin
          state_d = S_CJ;
        end
      end
      S_CJ: begin
        rom_addr  = cj_addr;
        cc_term_d = {{(CT_W-CODE_W){1'b0}}, cc_q} * CODE_GAIN;
        state_d   = S_CJ_RD;
      end
      S_CJ_RD: begin
        // rom_q holds the cold-junction voltage; fetch entry 0 next
        v_d     = {{(V_W-CT_W){1'b0}}, cc_term_q} + rom_scaled;
        state_d = S_LO;
      end
      S_LO: begin
        lo_s_d   = rom_scaled;
        rom_addr = AddrW'(1);
        idx_d    = AddrW'(1);
        state_d  = S_SEARCH;
      end
      S_SEARCH: begin
        if (hit) begin
          seg_d   = idx_q - 1'b1;
          den_d   = rom_scaled - lo_s_q;
          diff_d  = v_q - lo_s_q;
          state_d = S_FRAC;
        end else if (idx_q == AddrW'(LastIdx)) begin
          res_d   = tc_off_w;
          ok_d    = 1'b0;
          state_d = S_OUT;
        end else begin
          rom_addr = idx_q + 1'b1;
          idx_d    = idx_q + 1'b1;
          lo_s_d   = rom_scaled;
        end
      end
      S_FRAC: begin
        div_req.start    = 1'b1;
        div_req.rem_init = frac_num[FRAC_NUM_W-1:FRAC_QW];
        div_req.low      = frac_num[FRAC_QW-1:0];
        div_req.divisor  = {den_q, 1'b0};
        div_req.steps    = DIV_CNT_W'(FRAC_QW);
        state_d          = S_FRAC_WAIT;
      end
      S_FRAC_WAIT: begin
        if (div_rsp.done) begin
          res_d = $signed({{(WIDE_W-AddrW-8){1'b0}}, seg_q, 8'b0})
                  + $signed({{(WIDE_W-FRAC_QW){1'b0}}, div_rsp.quot[FRAC_QW-1:0]})
                  + tc_off_w;
          ok_d    = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // Hold until the output register is free, then saturate and present
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          if (res_q > SAT_HI) begin
            temp_d = SAT_HI[OUT_W-1:0];
          end else if (res_q < SAT_LO) begin
            temp_d = SAT_LO[OUT_W-1:0];
          end else begin
            temp_d = res_q[OUT_W-1:0];
          end
          in_range_d = ok_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      temp_q      <= '0;
      in_range_q  <= 1'b0;
      tc_off_q    <= '0;
      th_off_q    <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      temp_q      <= temp_d;
      in_range_q  <= in_range_d;
      tc_off_q    <= tc_off_d;
      th_off_q    <= th_off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    cc_q         <= cc_d;
    jc_q         <= jc_d;
    jt_q         <= jt_d;
    res_q        <= res_d;
    ok_q         <= ok_d;
    therm_num_q  <= therm_num_d;
    therm_prod_q <= therm_prod_d;
    cc_term_q    <= cc_term_d;
    v_q          <= v_d;
    lo_s_q       <= lo_s_d;
    den_q        <= den_d;
    diff_q       <= diff_d;
    idx_q        <= idx_d;
    seg_q        <= seg_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.temperature = temp_q;
  assign out_o.in_range    = in_range_q;

  // A new result only appears out of the output state
  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("result appeared outside the output state");

  // The divider is never restarted mid-run
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // Search index stays inside the table
  a_search_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEARCH |-> (idx_q != '0) && (idx_q <= AddrW'(LastIdx)))
    else $error("table search index out of range");

  // An input transfer always launches the thermistor conversion
  a_in_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == S_JT)
    else $error("input transfer did not start processing");

endmodule

@@ test/tb_thermocouple_cjc_linearizer_top.sv @@
// ----------------------------------------------------------------------------
// tb_thermocouple_cjc_linearizer_top: self-checking bench for the linearizer
// Drives thermistor and thermocouple conversions through the valid/ready
// channels and predicts every temperature in fixed point. Each result is
// checked against the oldest pending prediction. Offset registers go through
// several settings, the limits among them. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_thermocouple_cjc_linearizer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tcl_pkg::*;

  localparam int TABLE_POINTS  = 151;
  localparam int LONG_HOLD     = 3000;      // receiver hold-off, long enough to back up the input
  localparam int SETTLE_CYCLES = 250;       // longer than the slowest conversion
  localparam int CYCLE_LIMIT   = 2_500_000;
  localparam int MAX_REPORTS   = 40;

  // Type K table in microvolts at 0..150 degrees; entry 90 keeps its 3680
  localparam int TYPE_K_UV [TABLE_POINTS] = '{
    0, 39, 79, 119, 158, 198, 238, 277, 317, 357, 397, 437, 477, 517, 557, 597,
    637, 677, 718, 758, 798, 838, 879, 919, 960, 1000, 1041, 1081, 1122, 1163,
    1203, 1244, 1285, 1326, 1366, 1407, 1448, 1489, 1530, 1571, 1612, 1653, 1694,
    1735, 1776, 1817, 1858, 1899, 1941, 1982, 2023, 2064, 2106, 2147, 2188, 2230,
    2271, 2312, 2354, 2395, 2436, 2478, 2519, 2561, 2602, 2644, 2685, 2727, 2768,
    2810, 2851, 2893, 2934, 2976, 3017, 3059, 3100, 3142, 3184, 3225, 3267, 3308,
    3350, 3391, 3433, 3474, 3516, 3557, 3599, 3640, 3680, 3723, 3765, 3806, 3848,
    3889, 3931, 3972, 4013, 4055, 4096, 4138, 4179, 4220, 4262, 4303, 4344, 4385,
    4427, 4468, 4509, 4550, 4591, 4633, 4674, 4715, 4756, 4797, 4838, 4879, 4920,
    4961, 5002, 5043, 5084, 5124, 5165, 5206, 5247, 5288, 5328, 5369, 5410, 5450,
    5491, 5532, 5572, 5613, 5653, 5694, 5735, 5775, 5815, 5856, 5896, 5937, 5977,
    6017, 6058, 6098, 6138
  };

  typedef struct packed {
    logic signed [OUT_W-1:0] temperature;
    logic                    in_range;
  } reading_t;

  // Holds the offset registers and the readings still owed by the block
  class temp_scoreboard;
    logic signed [OUT_W-1:0] tc_offset;
    logic signed [OUT_W-1:0] th_offset;
    reading_t                expected_readings[$];
    int                      errors;

    function new();
      tc_offset = '0;
      th_offset = '0;
      errors    = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [OUT_W-1:0] value);
      if (idx == CFG_TC_OFFSET) tc_offset = value;
      else if (idx == CFG_TH_OFFSET) th_offset = value;
    endfunction

    function reading_t predict_reading(logic op_sel, logic [CODE_W-1:0] cc,
                                       logic [CODE_W-1:0] jc);
      reading_t r;
      longint   num, junction_q88, cj, volts, lo, hi, den, t;
      bit       found;
      // thermistor in Q8.8, rounded half up via a floor divide
      num = 2 * (longint'(jc) * 330000 - 108103680) + 12702;
      if (num < 0) junction_q88 = -((-num + 25403) / 25404);
      else junction_q88 = num / 25404;
      junction_q88 += 2560 + longint'(th_offset);
      found = 1'b1;
      if (op_sel == OP_THERMISTOR) begin
        t = junction_q88;
      end else begin
        cj = (junction_q88 < 0) ? 0 : junction_q88 / 256;
        if (cj > TABLE_POINTS - 1) cj = TABLE_POINTS - 1;
        volts = longint'(cc) * 859375 + longint'(TYPE_K_UV[cj]) * 190584;
        found = 1'b0;
        t = 0;
        // first segment holding the voltage, both ends inclusive
        for (int i = 1; i < TABLE_POINTS && !found; i++) begin
          lo = longint'(TYPE_K_UV[i-1]) * 190584;
          hi = longint'(TYPE_K_UV[i]) * 190584;
          if (hi > lo && volts >= lo && volts <= hi) begin
            den   = hi - lo;
            t     = 256 * (i - 1) + (512 * (volts - lo) + den) / (2 * den);
            found = 1'b1;
          end
        end
        t += longint'(tc_offset);
      end
      if (t > 32767) t = 32767;
      else if (t < -32768) t = -32768;
      r.temperature = OUT_W'(t);
      r.in_range    = found;
      return r;
    endfunction

    function void note_conversion(logic op_sel, logic [CODE_W-1:0] cc,
                                  logic [CODE_W-1:0] jc);
      expected_readings.push_back(predict_reading(op_sel, cc, jc));
    endfunction

    function void check_reading(logic signed [OUT_W-1:0] temp, logic ok);
      reading_t want;
      if (expected_readings.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t ERROR unexpected result: expected none, actual temperature %0d in_range %0b",
                   $time, temp, ok);
        errors++;
        return;
      end
      want = expected_readings.pop_front();
      if (temp !== want.temperature) begin
        if (errors < MAX_REPORTS)
          $display("%0t ERROR temperature: expected %0d, actual %0d",
                   $time, want.temperature, temp);
        errors++;
      end
      if (ok !== want.in_range) begin
        if (errors < MAX_REPORTS)
          $display("%0t ERROR in_range: expected %0b, actual %0b", $time, want.in_range, ok);
        errors++;
      end
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   hold_off_req = 1'b0;   // raised by the sender, cleared by the receiver
  int   cycle_count;

  temp_scoreboard board;

  tcl_in_if  in_if ();
  tcl_out_if out_if ();
  tcl_cfg_if cfg_if ();

  thermocouple_cjc_linearizer_top #(
    .TableEntries(TABLE_POINTS)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hold reset, release it on a rising edge, never assert it again
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Observe every transfer; check results first so a stray one is never masked
  always @(posedge clk) begin
    if (out_if.valid && out_if.ready)
      board.check_reading(out_if.temperature, out_if.in_range);
    if (cfg_if.valid && cfg_if.ready)
      board.write_register(cfg_if.index, cfg_if.data);
    if (in_if.valid && in_if.ready)
      board.note_conversion(in_if.op, in_if.couple_code, in_if.junction_code);
  end

  // Receiver: stall on a pattern of segments; honor a long hold-off on request
  initial begin : result_sink
    int seg_left, mode;
    seg_left = 0;
    mode     = 0;
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        // block the output long enough for the input side to back up
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_req = 1'b0;
        out_if.ready <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(10, 200);
        end
        seg_left--;
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          2: out_if.ready <= ($urandom_range(0, 5) == 0);
          default: out_if.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Stop a hung run
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_thermocouple_cjc_linearizer_top NOT OK");
    $finish;
  end

  // Offer one conversion and hold it until the transfer; valid stays high
  task automatic send_reading(input logic op_sel, input logic [CODE_W-1:0] cc,
                              input logic [CODE_W-1:0] jc);
    in_if.valid         <= 1'b1;
    in_if.op            <= op_sel;
    in_if.couple_code   <= cc;
    in_if.junction_code <= jc;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic idle_input(input int n);
    in_if.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [OUT_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Write both offsets; call only with the block idle
  task automatic configure(input logic [OUT_W-1:0] tc_off, input logic [OUT_W-1:0] th_off);
    write_register(CFG_TC_OFFSET, tc_off);
    write_register(CFG_TH_OFFSET, th_off);
  endtask

  function automatic logic [OUT_W-1:0] random_offset();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return OUT_W'(int'($urandom_range(0, 20480)) - 10240);
    endcase
  endfunction

  // Random conversions in bursts with random gaps. Most couple codes stay low
  // enough to land inside the table; the rest cover the whole code range.
  task automatic run_random_phase(input int n_items, input bit hold_midway,
                                  input bit drain_midway);
    int               sent, burst, gap;
    logic             op_sel;
    logic [CODE_W-1:0] cc, jc;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < n_items; k++) begin
        op_sel = ($urandom_range(0, 3) != 0) ? OP_THERMOCOUPLE : OP_THERMISTOR;
        jc     = CODE_W'($urandom_range(0, 1023));
        cc     = ($urandom_range(0, 9) < 7) ? CODE_W'($urandom_range(0, 700))
                                            : CODE_W'($urandom_range(0, 1023));
        send_reading(op_sel, cc, jc);
        sent++;
        // keep offering while the receiver holds off
        if (hold_midway && sent == n_items / 3) hold_off_req = 1'b1;
        // pause until every owed result is back
        if (drain_midway && sent == n_items / 2) begin
          idle_input(1);
          wait_drained();
        end
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) idle_input(gap);
    end
  endtask

  initial begin : stimulus
    board = new();
    in_if.valid         <= 1'b0;
    in_if.op            <= OP_THERMISTOR;
    in_if.couple_code   <= '0;
    in_if.junction_code <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= CFG_TC_OFFSET;
    cfg_if.data         <= '0;
    @(posedge rst_n);
    @(posedge clk);

    // Zero offsets: code extremes, table ends, exact entry hits, entry 90
    configure(16'h0000, 16'h0000);
    send_reading(OP_THERMISTOR,   10'd0,     10'd0);
    send_reading(OP_THERMISTOR,   10'd0,     10'd1023);
    send_reading(OP_THERMOCOUPLE, 10'd0,     10'd0);      // lower end of the first segment
    send_reading(OP_THERMOCOUPLE, 10'd0,     10'd1023);   // lands exactly on an entry
    send_reading(OP_THERMOCOUPLE, 10'd1023,  10'd1023);   // above the table
    send_reading(OP_THERMOCOUPLE, 10'd808,   10'd0);
    send_reading(OP_THERMOCOUPLE, 10'd816,   10'd0);      // just below the 3680 entry
    send_reading(OP_THERMOCOUPLE, 10'd825,   10'd0);      // just above it
    send_reading(OP_THERMOCOUPLE, 10'h155,   10'h2AA);
    send_reading(OP_THERMOCOUPLE, 10'h2AA,   10'h155);
    idle_input(1);
    wait_drained();

    // Offsets at opposite limits: saturation both ways, cold junction below zero
    configure(16'h7FFF, 16'h8000);
    send_reading(OP_THERMISTOR,   10'd0,     10'd0);
    send_reading(OP_THERMOCOUPLE, 10'd0,     10'd512);
    send_reading(OP_THERMOCOUPLE, 10'd500,   10'd1023);
    send_reading(OP_THERMOCOUPLE, 10'd1023,  10'd0);
    idle_input(1);
    wait_drained();

    // Swapped limits: cold junction clamps to the last entry
    configure(16'h8000, 16'h7FFF);
    send_reading(OP_THERMISTOR,   10'd0,     10'd1023);
    send_reading(OP_THERMOCOUPLE, 10'd0,     10'd1023);   // top of the last segment
    send_reading(OP_THERMOCOUPLE, 10'd1,     10'd1023);   // just past the table
    send_reading(OP_THERMOCOUPLE, 10'd0,     10'd0);

    // Random phases, each under a fresh pair of offsets
    for (int p = 0; p < 6; p++) begin
      idle_input(1);
      wait_drained();
      configure(random_offset(), random_offset());
      run_random_phase(300, p == 1, p == 3);
    end

    // Drain, then watch a while for anything stray
    idle_input(1);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0)
      $display("tb_thermocouple_cjc_linearizer_top OK");
    else
      $display("tb_thermocouple_cjc_linearizer_top NOT OK");
    $finish;
  end

endmodule
